// ----- hdl/assert_macros.svh -----
// assertion helpers used by the datapath (hbc_dp)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define AST_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies the consequence in the next cycle
`define AST_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/hbc_pkg.sv -----
`timescale 1ns / 1ps
package hbc_pkg;

	localparam int NUM_SETS_DEF = 13;
	localparam int NUM_WAYS_DEF = 5;

	localparam logic [7:0]  CNT_MAX     = 8'hff;
	localparam logic [31:0] STAMP_LIMIT = 32'hffffffff;

	// remainder unit shifts in this many block number bits per cycle
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = 32 / MOD_DIGIT;
	localparam int MCW       = $clog2(MOD_STEPS);

	localparam logic [1:0] OP_GET     = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_PIN     = 2'd2;
	localparam logic [1:0] OP_UNPIN   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	typedef struct packed {
		logic [31:0] dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic [31:0] stamp;
		logic        vld;
	} entry_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic set_home;
		logic rd;
		logic look;
		logic next_set;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic in_get;
		logic in_bad;
		logic look_done;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/hbc_ifs.sv -----
`timescale 1ns / 1ps
interface hbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] device;
	logic [31:0] block_number;
	logic [31:0] now;
	logic [3:0]  handle_set;
	logic [2:0]  handle_way;

	modport source (output valid, operation, device, block_number, now, handle_set,
		handle_way, input ready);
	modport sink (input valid, operation, device, block_number, now, handle_set,
		handle_way, output ready);
endinterface

interface hbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] result_set;
	logic [2:0] result_way;
	logic       hit;
	logic       need_read;
	logic [1:0] status;

	modport source (output valid, result_set, result_way, hit, need_read, status,
		input ready);
	modport sink (input valid, result_set, result_way, hit, need_read, status,
		output ready);
endinterface

// ----- hdl/hashed_buffer_cache_lru_tags.sv -----
`timescale 1ns / 1ps
// tag store of a block cache, NUM_SETS sets of NUM_WAYS ways. one item in,
// one result item out. get (device, block_number) searches only the home set,
// block_number mod NUM_SETS; a hit bumps the count (saturating, status 2) and
// restamps the way. a miss recycles the free way (count 0) with the oldest
// stamp below all ones, lowest way on ties, first in the home set and then
// the following sets in wrapping order; status 1 when no set has one.
// release, pin and unpin adjust the count of the handle (set, way); an
// out-of-range handle gives an all-zero result. one item is worked at a time:
// a get is accepted, then passes the remainder unit (4 bits a cycle), then
// for each set visited a registered memory read followed by a compare of all
// ways in parallel and write back, then loading of the output register; a
// handle op skips the remainder unit and an out-of-range handle goes straight
// to the output load. the next item is accepted while the previous result
// waits in the output register; a second result stalls in the load step
// until the output register frees up. rows are cleared at reset by one valid
// flop per set, no sweep.
module hashed_buffer_cache_lru_tags #(
	parameter int NUM_SETS = hbc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = hbc_pkg::NUM_WAYS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hbc_req_if.sink   req,
	hbc_rsp_if.source rsp
);

	// command and status between sequencer and datapath
	hbc_pkg::cmd_t cmd;
	hbc_pkg::sts_t sts;

	// sequencer: remainder, read, compare, scan and output steps
	hbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// set memory, compare logic and result registers
	hbc_dp #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- hdl/hbc_ctrl.sv -----
`timescale 1ns / 1ps
module hbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hbc_pkg::sts_t sts,
	output hbc_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MOD  = 5'b00010,
		S_READ = 5'b00100,
		S_LOOK = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [hbc_pkg::MCW-1:0] mcnt_q;
	logic mlast;

	assign mlast    = mcnt_q == hbc_pkg::MCW'(hbc_pkg::MOD_STEPS - 1);
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_get) state_d = S_MOD;
					else if (sts.in_bad) state_d = S_PUT;
					else state_d = S_READ;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (mlast) begin
					cmd.set_home = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				if (sts.look_done) state_d = S_PUT;
				else begin
					cmd.next_set = 1'b1;
					state_d = S_READ;
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) mcnt_q <= '0;
			else if (cmd.mod_step) mcnt_q <= mcnt_q + 1'b1;
		end
	end

endmodule

// ----- hdl/hbc_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hbc_dp #(
	parameter int NUM_SETS = hbc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = hbc_pkg::NUM_WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hbc_req_if.sink       req,
	hbc_rsp_if.source     rsp,
	input  hbc_pkg::cmd_t cmd,
	output hbc_pkg::sts_t sts
);

	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	typedef hbc_pkg::entry_t [NUM_WAYS-1:0] row_t;

	row_t mem [NUM_SETS];
	row_t rd_q;
	logic rd_ok_q;
	logic [NUM_SETS-1:0] row_ok_q;

	// captured item
	logic        get_q;
	logic [1:0]  op_q;
	logic [31:0] dev_q, blk_q, now_q, blk_sh_q;
	logic [3:0]  hs_q;
	logic [2:0]  hw_q;

	logic [SW-1:0] r_q, r_d, cur_q, sc_q;
	logic [SW:0]   t;

	// pending and output results
	logic [3:0] res_set_q, o_set_q;
	logic [2:0] res_way_q, o_way_q;
	logic res_hit_q, res_rd_q, o_hit_q, o_rd_q, o_v_q;
	logic [1:0] res_st_q, o_st_q;

	row_t row, new_row;
	hbc_pkg::entry_t old_e, new_e;
	logic hit, found, first, last, done, wr;
	logic [WW-1:0] hit_w, free_w, sel_w;
	logic [31:0] best;
	logic [3:0] l_set;
	logic [2:0] l_way;
	logic l_hit, l_rd;
	logic [1:0] l_st;

	assign sts.in_get    = req.operation == hbc_pkg::OP_GET;
	assign sts.in_bad    = (32'(req.handle_set) >= NUM_SETS) || (32'(req.handle_way) >= NUM_WAYS);
	assign sts.out_free  = !o_v_q || rsp.ready;
	assign sts.look_done = done;

	// remainder by the set count, MOD_DIGIT block number bits per step
	always_comb begin
		r_d = r_q;
		for (int i = 0; i < hbc_pkg::MOD_DIGIT; i++) begin
			t = {r_d, blk_sh_q[31-i]};
			if (t >= (SW+1)'(NUM_SETS)) t = t - (SW+1)'(NUM_SETS);
			r_d = t[SW-1:0];
		end
	end

	assign row   = rd_ok_q ? rd_q : '0;
	assign first = sc_q == '0;
	assign last  = sc_q == SW'(NUM_SETS - 1);

	always_comb begin
		hit   = 1'b0;
		hit_w = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row[w].dev == dev_q && row[w].blk == blk_q) begin
				hit   = 1'b1;
				hit_w = WW'(w);
			end
		end
		found  = 1'b0;
		free_w = '0;
		best   = hbc_pkg::STAMP_LIMIT;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (row[w].cnt == 8'd0 && row[w].stamp < best) begin
				best   = row[w].stamp;
				found  = 1'b1;
				free_w = WW'(w);
			end
		end
	end

	always_comb begin
		sel_w = free_w;
		if (!get_q) sel_w = WW'(hw_q);
		else if (first && hit) sel_w = hit_w;
		old_e = row[sel_w];
		new_e = old_e;
		l_set = hs_q;
		l_way = hw_q;
		l_hit = 1'b0;
		l_rd  = 1'b0;
		l_st  = hbc_pkg::ST_OK;
		wr    = 1'b1;
		done  = 1'b1;
		if (!get_q) begin
			if (op_q == hbc_pkg::OP_PIN) begin
				if (old_e.cnt == hbc_pkg::CNT_MAX) l_st = hbc_pkg::ST_SAT;
				else new_e.cnt = old_e.cnt + 8'd1;
			end else begin
				if (old_e.cnt == 8'd0) l_st = hbc_pkg::ST_SAT;
				else new_e.cnt = old_e.cnt - 8'd1;
			end
		end else if (first && hit) begin
			if (old_e.cnt == hbc_pkg::CNT_MAX) l_st = hbc_pkg::ST_SAT;
			else new_e.cnt = old_e.cnt + 8'd1;
			new_e.stamp = now_q;
			new_e.vld   = 1'b1;
			l_set = 4'(cur_q);
			l_way = 3'(sel_w);
			l_hit = 1'b1;
			l_rd  = !old_e.vld;
		end else if (found) begin
			new_e = '{dev: dev_q, blk: blk_q, cnt: 8'd1, stamp: now_q, vld: 1'b1};
			l_set = 4'(cur_q);
			l_way = 3'(sel_w);
			l_rd  = 1'b1;
		end else begin
			wr    = 1'b0;
			done  = last;
			l_set = 4'd0;
			l_way = 3'd0;
			l_st  = hbc_pkg::ST_NOFREE;
		end
		new_row        = row;
		new_row[sel_w] = new_e;
	end

	// set memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.look && wr) mem[cur_q] <= new_row;
		if (cmd.rd) rd_q <= mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
			o_v_q    <= 1'b0;
			get_q    <= 1'b0;
			cur_q    <= '0;
			sc_q     <= '0;
			r_q      <= '0;
		end else begin
			if (cmd.look && wr) row_ok_q[cur_q] <= 1'b1;
			if (cmd.rd) rd_ok_q <= row_ok_q[cur_q];
			if (cmd.put) o_v_q <= 1'b1;
			else if (rsp.ready) o_v_q <= 1'b0;
			if (cmd.load) begin
				get_q <= sts.in_get;
				cur_q <= SW'(req.handle_set);
				sc_q  <= '0;
				r_q   <= '0;
			end else begin
				if (cmd.mod_step) r_q <= r_d;
				if (cmd.set_home) cur_q <= r_d;
				if (cmd.next_set) begin
					cur_q <= (cur_q == SW'(NUM_SETS - 1)) ? '0 : cur_q + 1'b1;
					sc_q  <= sc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req.operation;
			dev_q     <= req.device;
			blk_q     <= req.block_number;
			blk_sh_q  <= req.block_number;
			now_q     <= req.now;
			hs_q      <= req.handle_set;
			hw_q      <= req.handle_way;
			res_set_q <= 4'd0;
			res_way_q <= 3'd0;
			res_hit_q <= 1'b0;
			res_rd_q  <= 1'b0;
			res_st_q  <= hbc_pkg::ST_OK;
		end else begin
			if (cmd.mod_step) blk_sh_q <= blk_sh_q << hbc_pkg::MOD_DIGIT;
			if (cmd.look && done) begin
				res_set_q <= l_set;
				res_way_q <= l_way;
				res_hit_q <= l_hit;
				res_rd_q  <= l_rd;
				res_st_q  <= l_st;
			end
		end
		if (cmd.put) begin
			o_set_q <= res_set_q;
			o_way_q <= res_way_q;
			o_hit_q <= res_hit_q;
			o_rd_q  <= res_rd_q;
			o_st_q  <= res_st_q;
		end
	end

	assign rsp.valid      = o_v_q;
	assign rsp.result_set = o_set_q;
	assign rsp.result_way = o_way_q;
	assign rsp.hit        = o_hit_q;
	assign rsp.need_read  = o_rd_q;
	assign rsp.status     = o_st_q;

	`AST_NEXT(a_home_range, cmd.set_home, cur_q < SW'(NUM_SETS), "home set out of range")
	`AST_ALWAYS(a_scan_bound, !cmd.next_set || !last, "scan ran past the last set")
	`AST_NEXT(a_row_marked, cmd.look && wr, row_ok_q[$past(cur_q)], "written row not marked")

endmodule
